@@ sv/lbp_pkg.sv @@
// lbp_pkg: shared types, sizes and codes of the lbp histogram engine
// no dependencies; imported by every module of the block
`default_nettype none

package lbp_pkg;

   // frame geometry limits
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int MIN_SIZE   = 3;
   localparam int WIN_EDGE   = 2;

   // field widths
   localparam int DIM_W   = 11;
   localparam int PIX_W   = 8;
   localparam int CODE_W  = 8;
   localparam int CNT_W   = 20;
   localparam int BCNT_W  = 21;

   // derived sizes
   localparam int MAX_DIM   = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int SIZE_W    = ($clog2(MAX_DIM) + 1 > DIM_W) ? $clog2(MAX_DIM) + 1 : DIM_W;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int ROW_W     = $clog2(MAX_HEIGHT);
   localparam int BIN_COUNT = 256;
   localparam int HIST_AW   = $clog2(BIN_COUNT);
   localparam logic [CNT_W-1:0] BIN_LIMIT = {CNT_W{1'b1}};

   // reset values of the size registers
   localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
   localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

   // command codes
   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   // csr register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 1'b1;

   typedef struct packed {
      logic              command;
      logic              frame_start;
      logic [PIX_W-1:0]  pixel;
      logic [HIST_AW-1:0] bin_index;
   } req_type;

   typedef struct packed {
      logic              code_valid;
      logic [CODE_W-1:0] lbp_code;
      logic              frame_done;
      logic [BCNT_W-1:0] bin_count;
   } rsp_type;

   // line buffer control from the pipeline
   typedef struct packed {
      logic rd_en;   // pixel beat accepted, read its column
      logic adv;     // pixel in stage one retires, write back and shift window
   } line_ctrl_type;

   // histogram control from the pipeline
   typedef struct packed {
      logic issue;   // stage one retires, read its bin
      logic clear;   // the retiring item starts a frame
      logic wr_en;   // stage two retires with an increment
   } hist_ctrl_type;

endpackage

`default_nettype wire

@@ sv/lbp_histogram_engine.sv @@
// lbp_histogram_engine: top level, position tracking, pipeline control, csr
// depends on lbp_pkg, lbp_line_window, lbp_hist_store
//
// Usage:
//   req channel carries pixel beats (command 0) and bin read beats (command 1).
//   Pixels come in raster order; frame_start on a pixel clears the histogram
//   and the row/column position before that pixel counts.
//   rsp channel returns exactly one beat per req beat, in order: the code of
//   a completed 3x3 window (code_valid), frame_done on the last pixel of a
//   frame, or the bin count for a read beat.
//   csr channel writes image_width (index 0) and image_height (index 1);
//   csr_ready is always high. Write only while the block is idle.
// Timing:
//   an accepted beat is registered in stage one, then in stage two, which
//   drives rsp_valid; one beat per cycle sustained while rsp_ready is high.
//   Stage one reads the line memory, stage two holds the histogram read and
//   is the output register; the read-modify-write closes there with a bypass.
// Reset and stalls:
//   reset clears the position, the window and the histogram valid bits, and
//   loads 640 x 480. No clearing pass. While rsp_ready is low stage two holds
//   and one more beat is taken into stage one.
`default_nettype none

module lbp_histogram_engine
   import lbp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [DIM_W-1:0]      csr_wdata
);

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [DIM_W-1:0] v,
                                                    input logic [SIZE_W-1:0] hi);
      logic [SIZE_W-1:0] ext;
      ext = SIZE_W'(v);
      if (ext < SIZE_W'(MIN_SIZE)) begin
         return SIZE_W'(MIN_SIZE);
      end
      if (ext > hi) begin
         return hi;
      end
      return ext;
   endfunction

   logic [DIM_W-1:0]   width_ff;
   logic [DIM_W-1:0]   height_ff;
   logic [COL_W-1:0]   col_ff;
   logic [ROW_W-1:0]   row_ff;
   logic [COL_W-1:0]   pos_col;
   logic [ROW_W-1:0]   pos_row;
   logic [SIZE_W-1:0]  w_eff;
   logic [SIZE_W-1:0]  h_eff;
   logic               last_col;
   logic               last_row;
   logic               accept;
   logic               pix_accept;

   logic               s1_valid_ff;
   logic               s1_cmd_ff;
   logic               s1_fs_ff;
   logic               s1_elig_ff;
   logic               s1_done_ff;
   logic [HIST_AW-1:0] s1_bin_ff;
   logic               s1_adv;

   logic               s2_valid_ff;
   logic               s2_cmd_ff;
   logic               s2_elig_ff;
   logic               s2_done_ff;
   logic [CODE_W-1:0]  s2_code_ff;
   logic               s2_adv;

   logic [CODE_W-1:0]  code;
   logic [CNT_W-1:0]   count;
   logic [HIST_AW-1:0] hist_addr;
   line_ctrl_type      line_ctrl;
   hist_ctrl_type      hist_ctrl;

   // csr writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_wdata;
            CSR_HEIGHT: height_ff <= csr_wdata;
            default:    ;
         endcase
      end
   end

   // handshake
   assign s2_adv     = s2_valid_ff && rsp_ready;
   assign s1_adv     = s1_valid_ff && (!s2_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_adv;
   assign accept     = req_valid && req_ready;
   assign pix_accept = accept && (req_data.command == CMD_PIXEL);

   // position of the incoming pixel
   assign w_eff    = clamp_size(width_ff, SIZE_W'(MAX_WIDTH));
   assign h_eff    = clamp_size(height_ff, SIZE_W'(MAX_HEIGHT));
   assign pos_col  = req_data.frame_start ? '0 : col_ff;
   assign pos_row  = req_data.frame_start ? '0 : row_ff;
   assign last_col = SIZE_W'(pos_col) >= (w_eff - SIZE_W'(1));
   assign last_row = SIZE_W'(pos_row) >= (h_eff - SIZE_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (pix_accept) begin
         if (last_col) begin
            col_ff <= '0;
            row_ff <= last_row ? '0 : pos_row + ROW_W'(1);
         end else begin
            col_ff <= pos_col + COL_W'(1);
            row_ff <= pos_row;
         end
      end
   end

   // stage one: line memory read in flight
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff  <= req_data.command;
         s1_fs_ff   <= req_data.frame_start;
         s1_elig_ff <= (pos_row >= ROW_W'(WIN_EDGE)) && (pos_col >= COL_W'(WIN_EDGE));
         s1_done_ff <= last_col && last_row;
         s1_bin_ff  <= req_data.bin_index;
      end
   end

   assign line_ctrl.rd_en = pix_accept;
   assign line_ctrl.adv   = s1_adv && (s1_cmd_ff == CMD_PIXEL);

   lbp_line_window u_line (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (line_ctrl),
      .rd_col   (pos_col),
      .pixel_in (req_data.pixel),
      .code     (code)
   );

   // stage two: histogram read in flight, output register
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         s2_valid_ff <= 1'b1;
      end else if (s2_adv) begin
         s2_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_cmd_ff  <= s1_cmd_ff;
         s2_elig_ff <= s1_elig_ff && (s1_cmd_ff == CMD_PIXEL);
         s2_done_ff <= s1_done_ff && (s1_cmd_ff == CMD_PIXEL);
         s2_code_ff <= code;
      end
   end

   assign hist_addr       = (s1_cmd_ff == CMD_READ) ? s1_bin_ff : code;
   assign hist_ctrl.issue = s1_adv;
   assign hist_ctrl.clear = (s1_cmd_ff == CMD_PIXEL) && s1_fs_ff;
   assign hist_ctrl.wr_en = s2_adv && s2_elig_ff;

   lbp_hist_store u_hist (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (hist_ctrl),
      .rd_addr (hist_addr),
      .count   (count)
   );

   // result beat
   assign rsp_valid           = s2_valid_ff;
   assign rsp_data.code_valid = s2_elig_ff;
   assign rsp_data.lbp_code   = s2_elig_ff ? s2_code_ff : '0;
   assign rsp_data.frame_done = s2_done_ff;
   assign rsp_data.bin_count  = (s2_cmd_ff == CMD_READ) ? BCNT_W'(count) : '0;

endmodule

`default_nettype wire

@@ sv/lbp_line_window.sv @@
// lbp_line_window: two line buffers in one memory, the 3x3 window and the code
// depends on lbp_pkg
`default_nettype none

module lbp_line_window
   import lbp_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire line_ctrl_type       ctrl,
   input  wire logic [COL_W-1:0]    rd_col,
   input  wire logic [PIX_W-1:0]    pixel_in,
   output logic      [CODE_W-1:0]   code
);

   // upper line in the high byte, middle line in the low byte
   logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
   logic [2*PIX_W-1:0] rd_ff;
   logic [2*PIX_W-1:0] fwd_data_ff;
   logic               fwd_ff;
   logic [COL_W-1:0]   col_ff;
   logic [PIX_W-1:0]   pix_ff;
   logic [PIX_W-1:0]   win_ff [6];
   logic [PIX_W-1:0]   top;
   logic [PIX_W-1:0]   mid;
   logic [PIX_W-1:0]   ctr;
   logic [2*PIX_W-1:0] wr_data;
   logic               fwd_in;

   // line memory: read on accept, write back when the pixel retires
   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         rd_ff  <= line_mem[rd_col];
         col_ff <= rd_col;
         pix_ff <= pixel_in;
      end
      if (ctrl.adv) begin
         line_mem[col_ff] <= wr_data;
      end
   end

   // bypass when the retiring pixel writes the column being read
   assign fwd_in = ctrl.adv && (col_ff == rd_col);

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (ctrl.rd_en) begin
         fwd_ff <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         fwd_data_ff <= wr_data;
      end
   end

   assign top     = fwd_ff ? fwd_data_ff[2*PIX_W-1:PIX_W] : rd_ff[2*PIX_W-1:PIX_W];
   assign mid     = fwd_ff ? fwd_data_ff[PIX_W-1:0]       : rd_ff[PIX_W-1:0];
   assign wr_data = {mid, pix_ff};

   // window columns: left top/mid/bottom, center top/mid/bottom
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (ctrl.adv) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= top;
         win_ff[4] <= mid;
         win_ff[5] <= pix_ff;
      end
   end

   // code bits clockwise from top-left
   assign ctr = win_ff[4];

   always_comb begin
      code[0] = ctr < win_ff[0];
      code[1] = ctr < win_ff[3];
      code[2] = ctr < top;
      code[3] = ctr < mid;
      code[4] = ctr < pix_ff;
      code[5] = ctr < win_ff[5];
      code[6] = ctr < win_ff[2];
      code[7] = ctr < win_ff[1];
   end

endmodule

`default_nettype wire

@@ sv/lbp_hist_store.sv @@
// lbp_hist_store: histogram memory with per-bin valid bits and read-modify-write
// depends on lbp_pkg
`default_nettype none

module lbp_hist_store
   import lbp_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire hist_ctrl_type       ctrl,
   input  wire logic [HIST_AW-1:0]  rd_addr,
   output logic      [CNT_W-1:0]    count
);

   logic [CNT_W-1:0]   hist_mem [BIN_COUNT];
   logic [BIN_COUNT-1:0] valid_ff;
   logic [CNT_W-1:0]   rd_ff;
   logic [CNT_W-1:0]   fwd_data_ff;
   logic               fwd_ff;
   logic               zero_ff;
   logic               vld_ff;
   logic [HIST_AW-1:0] addr_ff;
   logic [CNT_W-1:0]   wr_data;

   // memory: read when stage one retires, write when stage two retires
   always_ff @(posedge clock) begin
      if (ctrl.issue) begin
         rd_ff       <= hist_mem[rd_addr];
         addr_ff     <= rd_addr;
         fwd_data_ff <= wr_data;
      end
      if (ctrl.wr_en) begin
         hist_mem[addr_ff] <= wr_data;
      end
   end

   // read qualifiers; a frame start clears all bins at once
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         fwd_ff   <= 1'b0;
         zero_ff  <= 1'b0;
         vld_ff   <= 1'b0;
      end else begin
         if (ctrl.issue) begin
            fwd_ff  <= ctrl.wr_en && (addr_ff == rd_addr);
            zero_ff <= ctrl.clear;
            vld_ff  <= valid_ff[rd_addr];
         end
         if (ctrl.issue && ctrl.clear) begin
            valid_ff <= '0;
         end else if (ctrl.wr_en) begin
            valid_ff[addr_ff] <= 1'b1;
         end
      end
   end

   // current count of the bin held in stage two
   always_comb begin
      priority if (zero_ff) begin
         count = '0;
      end else if (fwd_ff) begin
         count = fwd_data_ff;
      end else if (vld_ff) begin
         count = rd_ff;
      end else begin
         count = '0;
      end
   end

   // saturating increment
   assign wr_data = (count < BIN_LIMIT) ? count + CNT_W'(1) : count;

endmodule

`default_nettype wire

@@ sv/lbp_checker.sv @@
// lbp_checker: port-level assertions for the lbp histogram engine, with bind
// depends on lbp_pkg and lbp_histogram_engine
`default_nettype none

module lbp_checker
   import lbp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    rsp_valid,
   input  wire logic    rsp_ready,
   input  wire rsp_type rsp_data
);

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed while stalled");

   // a counted window never carries a bin count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.code_valid |-> rsp_data.bin_count == '0)
      else $error("code beat with bin count");

   // code is zero when no window was counted
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.code_valid |-> rsp_data.lbp_code == '0)
      else $error("lbp code without valid window");

   // frame end only on pixel beats, which carry no count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_done |-> rsp_data.bin_count == '0)
      else $error("frame done with bin count");

endmodule

bind lbp_histogram_engine lbp_checker u_lbp_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
